>>> rtl/psl_pkg.sv
package psl_pkg;

   // Fixed field widths of the request and response transactions.
   localparam int CMD_W      = 3;
   localparam int VALUE_W    = 32;
   localparam int POS_W      = 5;
   localparam int STATUS_W   = 2;
   localparam int COUNT_W    = 5;
   localparam int REMOVED_W  = 32;

   // Default sizing of the list.
   localparam int CAPACITY_DEF   = 16;
   localparam int DATA_WIDTH_DEF = 32;

   typedef logic [CMD_W-1:0]    cmd_type;
   typedef logic [STATUS_W-1:0] status_type;

   localparam cmd_type CMD_INS_FRONT = 3'd0;
   localparam cmd_type CMD_INS_BACK  = 3'd1;
   localparam cmd_type CMD_INS_AT    = 3'd2;
   localparam cmd_type CMD_DEL_FRONT = 3'd3;
   localparam cmd_type CMD_DEL_BACK  = 3'd4;
   localparam cmd_type CMD_DEL_AT    = 3'd5;

   localparam status_type ST_OK     = 2'd0;
   localparam status_type ST_BADPOS = 2'd1;
   localparam status_type ST_EMPTY  = 2'd2;
   localparam status_type ST_FULL   = 2'd3;

   typedef enum logic [1:0] {
      OP_NONE = 2'd0,
      OP_INS  = 2'd1,
      OP_DEL  = 2'd2
   } op_type;

   typedef enum logic [1:0] {
      RD_SLOT  = 2'd0,
      RD_BELOW = 2'd1,
      RD_ABOVE = 2'd2
   } rd_sel_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic       latch_req;
      logic       set_status;
      logic       rd_en;
      rd_sel_type rd_sel;
      logic       wr_en;
      logic       wr_from_read;
      logic       cur_load_len;
      logic       cur_load_slot;
      logic       cur_dec;
      logic       cur_inc;
      logic       len_inc;
      logic       len_dec;
      logic       take_removed;
      logic       load_rsp;
   } ctl_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      op_type op;
      logic   at_slot;
      logic   at_end;
   } sts_type;

endpackage

>>> rtl/positional_sequence_list_top.sv
// Bounded ordered list of up to CAPACITY words of DATA_WIDTH bits, front at
// position 1. Each request transaction carries one command (insert at front,
// back or a 1-based position; delete at front, back or a 1-based position) and
// yields exactly one response transaction with a status, the entry count after
// the command and the word a successful delete took out (zero otherwise). The
// entries live in a single memory with one write port and one registered read
// port, so shifting later entries takes a read step and a write step for each
// entry that moves (at most CAPACITY - 1). One transaction is worked on at a
// time. The response sits in its own register, so the next request is taken
// while the previous response still waits for rsp_ready. Stored words keep the
// low DATA_WIDTH bits of req_value; the count port shows the low 5 bits of the
// entry count. Reset empties the list; storage contents are never read before
// they are written.
module positional_sequence_list_top
   import psl_pkg::*;
#(
   parameter int CAPACITY   = CAPACITY_DEF,
   parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic [CMD_W-1:0]     req_command,
   input  logic [VALUE_W-1:0]   req_value,
   input  logic [POS_W-1:0]     req_position,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [STATUS_W-1:0]  rsp_status,
   output logic [COUNT_W-1:0]   rsp_count,
   output logic [REMOVED_W-1:0] rsp_removed_value
);

   // Command and status traffic between the sequencer and the datapath.
   ctl_type ctl;
   sts_type sts;

   // The sequencer walks each command through check, shift and response steps.
   psl_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .sts       (sts),
      .ctl       (ctl)
   );

   // The datapath holds the entry memory, the count, the cursor and the
   // response register, and decodes the latched command for the sequencer.
   psl_datapath #(
      .CAPACITY   (CAPACITY),
      .DATA_WIDTH (DATA_WIDTH)
   ) u_datapath (
      .clock             (clock),
      .reset             (reset),
      .ctl               (ctl),
      .sts               (sts),
      .req_command       (req_command),
      .req_value         (req_value),
      .req_position      (req_position),
      .rsp_status        (rsp_status),
      .rsp_count         (rsp_count),
      .rsp_removed_value (rsp_removed_value)
   );

endmodule

>>> rtl/psl_datapath.sv
module psl_datapath
   import psl_pkg::*;
#(
   parameter int CAPACITY   = CAPACITY_DEF,
   parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  ctl_type              ctl,
   output sts_type              sts,
   input  logic [CMD_W-1:0]     req_command,
   input  logic [VALUE_W-1:0]   req_value,
   input  logic [POS_W-1:0]     req_position,
   output logic [STATUS_W-1:0]  rsp_status,
   output logic [COUNT_W-1:0]   rsp_count,
   output logic [REMOVED_W-1:0] rsp_removed_value
);

   localparam int IDX_W = $clog2(CAPACITY);
   localparam int LEN_W = $clog2(CAPACITY + 1);
   localparam int CMP_W = ((LEN_W > POS_W) ? LEN_W : POS_W) + 1;

   // Latched request.
   cmd_type               cmd_ff;
   logic [DATA_WIDTH-1:0] value_ff;
   logic [POS_W-1:0]      pos_ff;

   // List state and walk cursor.
   logic [LEN_W-1:0]      length_ff, length_in;
   logic [IDX_W-1:0]      cursor_ff, cursor_in;
   logic [DATA_WIDTH-1:0] mem [CAPACITY];
   logic [DATA_WIDTH-1:0] rd_data_ff;
   logic [IDX_W-1:0]      rd_addr;
   logic [DATA_WIDTH-1:0] wr_data;

   // Per-transaction result and the response register.
   status_type            status_ff;
   logic [DATA_WIDTH-1:0] removed_ff;
   status_type            rsp_status_ff;
   logic [COUNT_W-1:0]    rsp_count_ff;
   logic [REMOVED_W-1:0]  rsp_removed_ff;

   // Decode of the latched command.
   status_type            chk_status;
   op_type                chk_op;
   logic [IDX_W-1:0]      slot;
   logic                  full;
   logic                  empty;
   logic [CMP_W-1:0]      pos_cmp;
   logic [CMP_W-1:0]      len_cmp;
   logic [CMP_W-1:0]      pos_less1;
   logic [LEN_W-1:0]      len_less1;

   logic [VALUE_W+DATA_WIDTH-1:0] value_ext;
   logic [DATA_WIDTH+REMOVED_W-1:0] removed_ext;
   logic [LEN_W+COUNT_W-1:0]        count_ext;

   assign value_ext   = {{DATA_WIDTH{1'b0}}, req_value};
   assign removed_ext = {{REMOVED_W{1'b0}}, removed_ff};
   assign count_ext   = {{COUNT_W{1'b0}}, length_ff};

   assign full      = (length_ff == LEN_W'(CAPACITY));
   assign empty     = (length_ff == '0);
   assign pos_cmp   = CMP_W'(pos_ff);
   assign len_cmp   = CMP_W'(length_ff);
   assign pos_less1 = pos_cmp - CMP_W'(1);
   assign len_less1 = length_ff - LEN_W'(1);

   always_comb begin
      chk_status = ST_OK;
      chk_op     = OP_NONE;
      slot       = '0;
      case (cmd_ff)
         CMD_INS_FRONT: begin
            if (full) chk_status = ST_FULL;
            else chk_op = OP_INS;
         end
         CMD_INS_BACK: begin
            slot = length_ff[IDX_W-1:0];
            if (full) chk_status = ST_FULL;
            else chk_op = OP_INS;
         end
         CMD_INS_AT: begin
            slot = pos_less1[IDX_W-1:0];
            if (pos_cmp == '0 || pos_cmp > len_cmp + CMP_W'(1)) chk_status = ST_BADPOS;
            else if (full) chk_status = ST_FULL;
            else chk_op = OP_INS;
         end
         CMD_DEL_FRONT: begin
            if (empty) chk_status = ST_EMPTY;
            else chk_op = OP_DEL;
         end
         CMD_DEL_BACK: begin
            slot = len_less1[IDX_W-1:0];
            if (empty) chk_status = ST_EMPTY;
            else chk_op = OP_DEL;
         end
         CMD_DEL_AT: begin
            slot = pos_less1[IDX_W-1:0];
            if (pos_cmp == '0 || pos_cmp > len_cmp) chk_status = ST_BADPOS;
            else chk_op = OP_DEL;
         end
         default: begin
            chk_status = ST_OK;
            chk_op     = OP_NONE;
         end
      endcase
   end

   assign sts.op      = chk_op;
   assign sts.at_slot = (cursor_ff == slot);
   assign sts.at_end  = (LEN_W'(cursor_ff) + LEN_W'(1) == length_ff);

   always_comb begin
      case (ctl.rd_sel)
         RD_SLOT:  rd_addr = slot;
         RD_BELOW: rd_addr = cursor_ff - IDX_W'(1);
         RD_ABOVE: rd_addr = cursor_ff + IDX_W'(1);
         default:  rd_addr = slot;
      endcase
   end

   assign wr_data = ctl.wr_from_read ? rd_data_ff : value_ff;

   always_comb begin
      cursor_in = cursor_ff;
      if (ctl.cur_load_len) cursor_in = length_ff[IDX_W-1:0];
      else if (ctl.cur_load_slot) cursor_in = slot;
      else if (ctl.cur_dec) cursor_in = cursor_ff - IDX_W'(1);
      else if (ctl.cur_inc) cursor_in = cursor_ff + IDX_W'(1);
   end

   always_comb begin
      length_in = length_ff;
      if (ctl.len_inc) length_in = length_ff + LEN_W'(1);
      else if (ctl.len_dec) length_in = length_ff - LEN_W'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         length_ff <= '0;
      end else begin
         length_ff <= length_in;
      end
   end

   always_ff @(posedge clock) begin
      cursor_ff <= cursor_in;
      if (ctl.latch_req) begin
         cmd_ff   <= req_command;
         value_ff <= value_ext[DATA_WIDTH-1:0];
         pos_ff   <= req_position;
      end
      if (ctl.set_status) begin
         status_ff  <= chk_status;
         removed_ff <= '0;
      end else if (ctl.take_removed) begin
         removed_ff <= rd_data_ff;
      end
      if (ctl.load_rsp) begin
         rsp_status_ff  <= status_ff;
         rsp_count_ff   <= count_ext[COUNT_W-1:0];
         rsp_removed_ff <= removed_ext[REMOVED_W-1:0];
      end
   end

   // List storage: one write and one registered read per cycle.
   always_ff @(posedge clock) begin
      if (ctl.wr_en) mem[cursor_ff] <= wr_data;
      if (ctl.rd_en) rd_data_ff <= mem[rd_addr];
   end

   assign rsp_status        = rsp_status_ff;
   assign rsp_count         = rsp_count_ff;
   assign rsp_removed_value = rsp_removed_ff;

   a_read_in_list: assert property (@(posedge clock) disable iff (reset)
      ctl.rd_en |-> LEN_W'(rd_addr) < length_ff)
      else $error("read outside the occupied part of the list");

   a_grow_not_full: assert property (@(posedge clock) disable iff (reset)
      ctl.len_inc |-> (length_ff < LEN_W'(CAPACITY)) && ctl.wr_en && !ctl.wr_from_read)
      else $error("list grows without storing the new value or while full");

   a_shrink_not_empty: assert property (@(posedge clock) disable iff (reset)
      ctl.len_dec |-> length_ff != '0)
      else $error("list shrinks while empty");

endmodule

>>> rtl/psl_ctrl.sv
module psl_ctrl
   import psl_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   input  sts_type sts,
   output ctl_type ctl
);

   typedef enum logic [7:0] {
      S_IDLE     = 8'b0000_0001,
      S_CHECK    = 8'b0000_0010,
      S_INS_STEP = 8'b0000_0100,
      S_INS_MOVE = 8'b0000_1000,
      S_DEL_TAKE = 8'b0001_0000,
      S_DEL_STEP = 8'b0010_0000,
      S_DEL_MOVE = 8'b0100_0000,
      S_DONE     = 8'b1000_0000
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   always_comb begin
      state_in = state_ff;
      ctl      = '0;
      case (state_ff)
         S_IDLE: begin
            ctl.latch_req = req_valid;
            if (req_valid) state_in = S_CHECK;
         end
         S_CHECK: begin
            ctl.set_status = 1'b1;
            case (sts.op)
               OP_INS: begin
                  ctl.cur_load_len = 1'b1;
                  state_in         = S_INS_STEP;
               end
               OP_DEL: begin
                  ctl.rd_en         = 1'b1;
                  ctl.rd_sel        = RD_SLOT;
                  ctl.cur_load_slot = 1'b1;
                  state_in          = S_DEL_TAKE;
               end
               default: state_in = S_DONE;
            endcase
         end
         S_INS_STEP: begin
            if (sts.at_slot) begin
               ctl.wr_en   = 1'b1;
               ctl.len_inc = 1'b1;
               state_in    = S_DONE;
            end else begin
               ctl.rd_en  = 1'b1;
               ctl.rd_sel = RD_BELOW;
               state_in   = S_INS_MOVE;
            end
         end
         S_INS_MOVE: begin
            ctl.wr_en        = 1'b1;
            ctl.wr_from_read = 1'b1;
            ctl.cur_dec      = 1'b1;
            state_in         = S_INS_STEP;
         end
         S_DEL_TAKE: begin
            ctl.take_removed = 1'b1;
            state_in         = S_DEL_STEP;
         end
         S_DEL_STEP: begin
            if (sts.at_end) begin
               ctl.len_dec = 1'b1;
               state_in    = S_DONE;
            end else begin
               ctl.rd_en  = 1'b1;
               ctl.rd_sel = RD_ABOVE;
               state_in   = S_DEL_MOVE;
            end
         end
         S_DEL_MOVE: begin
            ctl.wr_en        = 1'b1;
            ctl.wr_from_read = 1'b1;
            ctl.cur_inc      = 1'b1;
            state_in         = S_DEL_STEP;
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               ctl.load_rsp = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (ctl.load_rsp) rsp_valid_in = 1'b1;
      else if (rsp_ready) rsp_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;

   a_accept_to_check: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> state_ff == S_CHECK)
      else $error("accepted transaction did not move to the check step");

   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == S_DONE))
      else $error("response raised outside the done step");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      ctl.load_rsp |-> !rsp_valid_ff || rsp_ready)
      else $error("pending response overwritten");

endmodule

>>> tb/tb_top.sv
`timescale 1ns / 100ps

// Self-checking bench for the bounded positional list. A directed table opens
// the run, then a long stretch of random list traffic follows. Every accepted
// command transaction is run through a shadow copy of the list kept in the
// bench, and the outcome is queued; every accepted response transaction is
// compared against the oldest queued outcome.
module tb_top;
   import psl_pkg::*;

   localparam int LIST_DEPTH     = CAPACITY_DEF;
   localparam int RANDOM_ITEMS   = 1018;
   localparam int CALM_TAIL      = 150;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int SETTLE_CYCLES  = 40;

   // The package names six commands; the two leftover codes must act as no-ops.
   localparam cmd_type CMD_SPARE_6 = 3'd6;
   localparam cmd_type CMD_SPARE_7 = 3'd7;

   typedef struct packed {
      status_type           status;
      logic [COUNT_W-1:0]   count;
      logic [REMOVED_W-1:0] removed;
   } list_result_type;

   // One row of the directed table. When has_known is set, the outcome is
   // simple enough to write down by hand and is used in place of the shadow
   // list's answer.
   typedef struct packed {
      cmd_type            cmd;
      logic [VALUE_W-1:0] value;
      logic [POS_W-1:0]   pos;
      logic               has_known;
      list_result_type    known;
   } directed_row_type;

   localparam logic [31:0] ALL_ONES = 32'hFFFF_FFFF;

   // The table first pokes the empty list from every side, then fills it to
   // capacity with a mix of front, back and positional inserts, then checks
   // the full-list and bad-position rules, and finally drains a few entries.
   localparam directed_row_type DIRECTED_TABLE [0:31] = '{
      '{CMD_DEL_FRONT, ALL_ONES,      5'd31, 1'b1, '{ST_EMPTY,  5'd0,  32'h0}},
      '{CMD_DEL_BACK,  32'h0,         5'd0,  1'b1, '{ST_EMPTY,  5'd0,  32'h0}},
      '{CMD_DEL_AT,    32'h0,         5'd1,  1'b1, '{ST_BADPOS, 5'd0,  32'h0}},
      '{CMD_INS_AT,    32'h1234_5678, 5'd0,  1'b1, '{ST_BADPOS, 5'd0,  32'h0}},
      '{CMD_INS_AT,    32'h1234_5678, 5'd2,  1'b1, '{ST_BADPOS, 5'd0,  32'h0}},
      '{CMD_SPARE_6,   ALL_ONES,      5'd31, 1'b1, '{ST_OK,     5'd0,  32'h0}},
      '{CMD_SPARE_7,   32'h0,         5'd0,  1'b1, '{ST_OK,     5'd0,  32'h0}},
      '{CMD_INS_FRONT, ALL_ONES,      5'd0,  1'b1, '{ST_OK,     5'd1,  32'h0}},
      '{CMD_INS_BACK,  32'h0,         5'd31, 1'b1, '{ST_OK,     5'd2,  32'h0}},
      '{CMD_INS_AT,    32'h8000_0000, 5'd1,  1'b1, '{ST_OK,     5'd3,  32'h0}},
      '{CMD_INS_AT,    32'h0000_0001, 5'd4,  1'b1, '{ST_OK,     5'd4,  32'h0}},
      '{CMD_INS_AT,    32'h5555_5555, 5'd3,  1'b1, '{ST_OK,     5'd5,  32'h0}},
      '{CMD_INS_FRONT, 32'hAAAA_AAAA, 5'd0,  1'b1, '{ST_OK,     5'd6,  32'h0}},
      '{CMD_INS_BACK,  32'h0F0F_0F0F, 5'd0,  1'b1, '{ST_OK,     5'd7,  32'h0}},
      '{CMD_INS_AT,    32'hF0F0_F0F0, 5'd5,  1'b1, '{ST_OK,     5'd8,  32'h0}},
      '{CMD_INS_FRONT, 32'h0000_0009, 5'd0,  1'b1, '{ST_OK,     5'd9,  32'h0}},
      '{CMD_INS_BACK,  32'h0000_000A, 5'd0,  1'b1, '{ST_OK,     5'd10, 32'h0}},
      '{CMD_INS_AT,    32'h0000_000B, 5'd11, 1'b1, '{ST_OK,     5'd11, 32'h0}},
      '{CMD_INS_AT,    32'h0000_000C, 5'd2,  1'b1, '{ST_OK,     5'd12, 32'h0}},
      '{CMD_INS_FRONT, 32'h0000_000D, 5'd0,  1'b1, '{ST_OK,     5'd13, 32'h0}},
      '{CMD_INS_BACK,  32'h0000_000E, 5'd0,  1'b1, '{ST_OK,     5'd14, 32'h0}},
      '{CMD_INS_AT,    32'h0000_000F, 5'd7,  1'b1, '{ST_OK,     5'd15, 32'h0}},
      '{CMD_INS_AT,    32'h0000_0010, 5'd16, 1'b1, '{ST_OK,     5'd16, 32'h0}},
      '{CMD_INS_FRONT, 32'hDEAD_0001, 5'd0,  1'b1, '{ST_FULL,   5'd16, 32'h0}},
      '{CMD_INS_BACK,  32'hDEAD_0002, 5'd0,  1'b1, '{ST_FULL,   5'd16, 32'h0}},
      '{CMD_INS_AT,    32'hDEAD_0003, 5'd17, 1'b1, '{ST_FULL,   5'd16, 32'h0}},
      '{CMD_INS_AT,    32'hDEAD_0004, 5'd18, 1'b1, '{ST_BADPOS, 5'd16, 32'h0}},
      '{CMD_DEL_AT,    32'h0,         5'd17, 1'b1, '{ST_BADPOS, 5'd16, 32'h0}},
      '{CMD_DEL_AT,    32'h0,         5'd16, 1'b0, '{ST_OK,     5'd0,  32'h0}},
      '{CMD_DEL_FRONT, 32'h0,         5'd0,  1'b0, '{ST_OK,     5'd0,  32'h0}},
      '{CMD_DEL_BACK,  32'h0,         5'd0,  1'b0, '{ST_OK,     5'd0,  32'h0}},
      '{CMD_DEL_AT,    32'h0,         5'd0,  1'b1, '{ST_BADPOS, 5'd13, 32'h0}}
   };

   logic                 clock = 1'b0;
   logic                 reset;
   logic                 req_valid;
   logic                 req_ready;
   logic [CMD_W-1:0]     req_command;
   logic [VALUE_W-1:0]   req_value;
   logic [POS_W-1:0]     req_position;
   logic                 rsp_valid;
   logic                 rsp_ready = 1'b0;
   logic [STATUS_W-1:0]  rsp_status;
   logic [COUNT_W-1:0]   rsp_count;
   logic [REMOVED_W-1:0] rsp_removed_value;

   // Shadow copy of the list (index 0 is the front) and the outcomes that
   // are still waiting for their response transaction.
   logic [VALUE_W-1:0] shadow_list[$];
   list_result_type    pending_results[$];

   int  error_count = 0;
   int  idle_cycles = 0;
   int  stall_left  = 0;
   // While set, both sides insert random bursts of idle cycles.
   bit  idle_mode   = 1'b1;

   positional_sequence_list_top DUT (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_command       (req_command),
      .req_value         (req_value),
      .req_position      (req_position),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_status        (rsp_status),
      .rsp_count         (rsp_count),
      .rsp_removed_value (rsp_removed_value)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Applies one command to the shadow list and returns what the block must
   // answer. Position checks come before the full check on a positional
   // insert, and an empty list makes every delete position invalid.
   function automatic list_result_type apply_list_command(cmd_type cmd,
                                                          logic [VALUE_W-1:0] value,
                                                          logic [POS_W-1:0] pos);
      list_result_type res;
      int              used;
      bit              full;
      used = shadow_list.size();
      full = (used >= LIST_DEPTH);
      res  = '{ST_OK, 5'd0, 32'h0};
      case (cmd)
         CMD_INS_FRONT: begin
            if (full) res.status = ST_FULL;
            else shadow_list.push_front(value);
         end
         CMD_INS_BACK: begin
            if (full) res.status = ST_FULL;
            else shadow_list.push_back(value);
         end
         CMD_INS_AT: begin
            if (pos < 1 || pos > used + 1) res.status = ST_BADPOS;
            else if (full) res.status = ST_FULL;
            else shadow_list.insert(pos - 1, value);
         end
         CMD_DEL_FRONT: begin
            if (used == 0) res.status = ST_EMPTY;
            else res.removed = shadow_list.pop_front();
         end
         CMD_DEL_BACK: begin
            if (used == 0) res.status = ST_EMPTY;
            else res.removed = shadow_list.pop_back();
         end
         CMD_DEL_AT: begin
            if (pos < 1 || pos > used) res.status = ST_BADPOS;
            else begin
               res.removed = shadow_list[pos - 1];
               shadow_list.delete(pos - 1);
            end
         end
         default: ;
      endcase
      res.count = COUNT_W'(shadow_list.size());
      return res;
   endfunction

   // Presents one command transaction, holds it until the block takes it,
   // and queues the outcome. An optional burst of idle cycles comes first.
   // Acceptance is judged from the values seen at the clock edge, before
   // any of that edge's register updates land.
   task automatic send_command(input cmd_type cmd, input logic [VALUE_W-1:0] value,
                               input logic [POS_W-1:0] pos, input bit has_known,
                               input list_result_type known);
      list_result_type predicted;
      if (idle_mode && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 15)) @(posedge clock);
      end
      req_valid    <= 1'b1;
      req_command  <= cmd;
      req_value    <= value;
      req_position <= pos;
      do @(posedge clock); while (!req_ready);
      predicted = apply_list_command(cmd, value, pos);
      pending_results.push_back(has_known ? known : predicted);
   endtask

   // Response side: checks each accepted response transaction against the
   // oldest outcome and throttles rsp_ready in random bursts.
   always @(posedge clock) begin : response_side
      list_result_type want;
      if (reset) begin
         rsp_ready  <= 1'b0;
         stall_left = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (pending_results.size() == 0) begin
               $error("response transaction with no command outstanding");
               error_count++;
            end else begin
               want = pending_results.pop_front();
               if (rsp_status !== want.status) begin
                  $error("status: expected %0d, actual %0d", want.status, rsp_status);
                  error_count++;
               end
               if (rsp_count !== want.count) begin
                  $error("count: expected %0d, actual %0d", want.count, rsp_count);
                  error_count++;
               end
               if (rsp_removed_value !== want.removed) begin
                  $error("removed_value: expected %h, actual %h",
                         want.removed, rsp_removed_value);
                  error_count++;
               end
            end
         end
         if (stall_left != 0) begin
            stall_left--;
            rsp_ready <= 1'b0;
         end else if (idle_mode && $urandom_range(0, 5) == 0) begin
            stall_left = $urandom_range(0, 14);
            rsp_ready  <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // The watchdog ends a run in which neither channel moves for too long.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
         end
      end
   end

   initial begin : stimulus
      int                 row;
      int                 n;
      int                 insert_pct;
      int                 used;
      int                 pick;
      cmd_type            cmd;
      logic [VALUE_W-1:0] value;
      logic [POS_W-1:0]   pos;

      reset        <= 1'b1;
      req_valid    <= 1'b0;
      req_command  <= CMD_INS_FRONT;
      req_value    <= '0;
      req_position <= '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      for (row = 0; row < $size(DIRECTED_TABLE); row++) begin
         send_command(DIRECTED_TABLE[row].cmd, DIRECTED_TABLE[row].value,
                      DIRECTED_TABLE[row].pos, DIRECTED_TABLE[row].has_known,
                      DIRECTED_TABLE[row].known);
      end

      // Random traffic. Every 64 transactions the mix leans toward inserts,
      // toward deletes or neither, so the list swings between empty and full
      // again and again. Most positions are legal for the current count; the
      // rest are drawn from the whole field to hit the rejection paths.
      insert_pct = 50;
      for (n = 0; n < RANDOM_ITEMS; n++) begin
         if (n % 64 == 0) begin
            case ($urandom_range(0, 2))
               0: insert_pct = 85;
               1: insert_pct = 15;
               default: insert_pct = 50;
            endcase
            idle_mode = (n < RANDOM_ITEMS - CALM_TAIL) && ($urandom_range(0, 2) != 0);
         end

         // Let the block drain completely before sending more, once mid-run.
         if (n == RANDOM_ITEMS / 2) begin
            req_valid <= 1'b0;
            while (pending_results.size() != 0) @(posedge clock);
         end

         used  = shadow_list.size();
         pick  = $urandom_range(0, 99);
         value = $urandom();
         case ($urandom_range(0, 9))
            0: value = '0;
            1: value = ALL_ONES;
            default: ;
         endcase
         pos = POS_W'($urandom_range(0, 31));

         if (pick < 3) begin
            cmd = $urandom_range(0, 1) ? CMD_SPARE_6 : CMD_SPARE_7;
         end else if ($urandom_range(0, 99) < insert_pct) begin
            case ($urandom_range(0, 2))
               0: cmd = CMD_INS_FRONT;
               1: cmd = CMD_INS_BACK;
               default: begin
                  cmd = CMD_INS_AT;
                  if ($urandom_range(0, 99) >= 15)
                     pos = POS_W'($urandom_range(1, used + 1));
               end
            endcase
         end else begin
            case ($urandom_range(0, 2))
               0: cmd = CMD_DEL_FRONT;
               1: cmd = CMD_DEL_BACK;
               default: begin
                  cmd = CMD_DEL_AT;
                  if (used > 0 && $urandom_range(0, 99) >= 15)
                     pos = POS_W'($urandom_range(1, used));
               end
            endcase
         end
         send_command(cmd, value, pos, 1'b0, '0);
      end
      req_valid <= 1'b0;

      // Wait for the last responses, then give the block time to show any
      // stray response transaction before judging the run.
      while (pending_results.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (error_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule

>>> positional_sequence_list_top.f
rtl/psl_pkg.sv
rtl/psl_datapath.sv
rtl/psl_ctrl.sv
rtl/positional_sequence_list_top.sv
tb/tb_top.sv
